/* hw/rtl/dmsr_pkg.sv */
// Shared constants and types for the dual motor speed ramp block.
// No dependencies; used by the channel interfaces and the top level.
package dmsr_pkg;

    // Field widths of the command and result beats
    localparam int OPCODE_W = 3;
    localparam int ACTION_W = 3;
    localparam int REQ_W    = 8;
    localparam int DUTY_W   = 7;
    localparam int SPEED_W  = 8;
    localparam int RAMP_W   = 8;
    localparam int ALPHA_W  = 9;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [OPCODE_W-1:0]       opcode_t;
    typedef logic [ACTION_W-1:0]       action_t;

    // Command opcodes
    localparam opcode_t OP_TICK          = 3'd0;
    localparam opcode_t OP_FORWARD       = 3'd1;
    localparam opcode_t OP_BACKWARD      = 3'd2;
    localparam opcode_t OP_BRAKE_SUPPLY  = 3'd3;
    localparam opcode_t OP_BRAKE_GROUND  = 3'd4;

    // Bridge drive actions
    localparam action_t ACT_UNCHANGED    = 3'd0;
    localparam action_t ACT_RUN_CW       = 3'd1;
    localparam action_t ACT_RUN_CCW      = 3'd2;
    localparam action_t ACT_NEUTRAL      = 3'd3;
    localparam action_t ACT_BRAKE_SUPPLY = 3'd4;
    localparam action_t ACT_BRAKE_GROUND = 3'd5;

    // Register indexes, selected by paddr[2]
    localparam logic REG_RAMP_PERIOD  = 1'b0;
    localparam logic REG_FILTER_ALPHA = 1'b1;

    // Limits and reset values
    localparam logic [REQ_W-1:0]   SPEED_LIMIT  = 8'd100;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 9'd102;
    localparam logic [RAMP_W-1:0]  RAMP_RESET   = 8'd0;

endpackage

/* hw/rtl/dmsr_in_if.sv */
// Command channel: valid/ready handshake carrying one motor command beat.
// Depends on dmsr_pkg for field widths.
interface dmsr_in_if #(
    parameter int SENSE_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic [dmsr_pkg::OPCODE_W-1:0] opcode;
    logic                          motor_select;
    logic [dmsr_pkg::REQ_W-1:0]    speed_request;
    logic [SENSE_BITS-1:0]         sense_sample;

    modport source (
        output valid, opcode, motor_select, speed_request, sense_sample,
        input  ready
    );

    modport sink (
        input  valid, opcode, motor_select, speed_request, sense_sample,
        output ready
    );
endinterface

/* hw/rtl/dmsr_out_if.sv */
// Result channel: valid/ready handshake carrying one drive result beat.
// Depends on dmsr_pkg for field widths.
interface dmsr_out_if #(
    parameter int SENSE_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic                          motor_id;
    logic [dmsr_pkg::ACTION_W-1:0] drive_action;
    logic [dmsr_pkg::DUTY_W-1:0]   duty;
    logic signed [dmsr_pkg::SPEED_W-1:0] target_speed;
    logic signed [dmsr_pkg::SPEED_W-1:0] present_speed;
    logic [SENSE_BITS-1:0]         filtered_current;

    modport source (
        output valid, motor_id, drive_action, duty, target_speed, present_speed,
               filtered_current,
        input  ready
    );

    modport sink (
        input  valid, motor_id, drive_action, duty, target_speed, present_speed,
               filtered_current,
        output ready
    );
endinterface

/* hw/rtl/dual_motor_speed_ramp.sv */
// Dual motor speed ramp controller with per-motor current-sense filter.
// Command register feeds one compute stage (one 9 x (SENSE_BITS+9) multiply)
// into the result register, where the result beat is held until taken.
// Throughput: one command per cycle while out_ch.ready does not stall it.
// Reset (rst_n low, asynchronous): speeds, targets and filters cleared,
// ramp_period 0, filter_alpha 102, both stages empty.
// Depends on dmsr_pkg, dmsr_in_if and dmsr_out_if.
module dual_motor_speed_ramp #(
    parameter int NUM_MOTORS = 2,
    parameter int SENSE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dmsr_in_if.sink                       in_ch,
    dmsr_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dmsr_pkg::APB_AW-1:0]   paddr,
    input  logic [dmsr_pkg::APB_DW-1:0]   pwdata,
    output logic [dmsr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int  FW        = SENSE_BITS + 8;
    localparam logic HAS_RIGHT = (NUM_MOTORS > 1);

    // Configuration registers
    logic [dmsr_pkg::RAMP_W-1:0]  ramp_period_reg;
    logic [dmsr_pkg::ALPHA_W-1:0] filter_alpha_reg;

    // Command stage
    logic                          stage_valid_reg;
    logic [dmsr_pkg::OPCODE_W-1:0] in_opcode_reg;
    logic                          in_motor_reg;
    logic [dmsr_pkg::REQ_W-1:0]    in_req_reg;
    logic [SENSE_BITS-1:0]         in_sample_reg;

    // Per-motor state
    dmsr_pkg::speed_t target_reg [NUM_MOTORS];
    dmsr_pkg::speed_t speed_reg  [NUM_MOTORS];
    logic [FW-1:0]    filt_reg   [NUM_MOTORS];

    // Result stage
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_motor_reg;
    logic [dmsr_pkg::ACTION_W-1:0] out_action_reg;
    logic [dmsr_pkg::DUTY_W-1:0]   out_duty_reg;
    dmsr_pkg::speed_t              out_target_reg;
    dmsr_pkg::speed_t              out_speed_reg;
    logic [SENSE_BITS-1:0]         out_filt_reg;

    logic advance;
    logic cfg_write;

    // Compute signals
    logic                          motor_ok;
    dmsr_pkg::speed_t              target_cur;
    dmsr_pkg::speed_t              speed_cur;
    logic [FW-1:0]                 filt_cur;
    dmsr_pkg::speed_t              target_next;
    dmsr_pkg::speed_t              speed_next;
    logic [FW-1:0]                 filt_next;
    logic [dmsr_pkg::ACTION_W-1:0] action;
    logic [dmsr_pkg::DUTY_W-1:0]   duty;
    logic [dmsr_pkg::DUTY_W-1:0]   req_clamped;
    logic [dmsr_pkg::ALPHA_W-1:0]  alpha_sat;
    logic signed [FW:0]            filt_diff;
    logic signed [FW+10:0]         filt_prod;
    logic signed [FW+10:0]         filt_sum;
    logic [FW-1:0]                 filt_new;

    // APB write decode; pready is always high
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_period_reg  <= dmsr_pkg::RAMP_RESET;
            filter_alpha_reg <= dmsr_pkg::ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == dmsr_pkg::REG_RAMP_PERIOD)
                ramp_period_reg <= pwdata[dmsr_pkg::RAMP_W-1:0];
            else
                filter_alpha_reg <= pwdata[dmsr_pkg::ALPHA_W-1:0];
        end
    end

    // Read back the selected register
    always_comb
    begin
        if (paddr[2] == dmsr_pkg::REG_FILTER_ALPHA)
            prdata = {{(dmsr_pkg::APB_DW-dmsr_pkg::ALPHA_W){1'b0}}, filter_alpha_reg};
        else
            prdata = {{(dmsr_pkg::APB_DW-dmsr_pkg::RAMP_W){1'b0}}, ramp_period_reg};
    end

    // Advance the command stage whenever the result register is free
    assign advance     = stage_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ch.ready)
            stage_valid_reg <= in_ch.valid;
    end

    // Capture the command beat
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_opcode_reg <= in_ch.opcode;
            in_motor_reg  <= in_ch.motor_select;
            in_req_reg    <= in_ch.speed_request;
            in_sample_reg <= in_ch.sense_sample;
        end
    end

    // Select the addressed motor's state
    assign motor_ok = HAS_RIGHT || !in_motor_reg;

    always_comb
    begin
        target_cur = '0;
        speed_cur  = '0;
        filt_cur   = '0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            if (int'(in_motor_reg) == i)
            begin
                target_cur = target_reg[i];
                speed_cur  = speed_reg[i];
                filt_cur   = filt_reg[i];
            end
        end
    end

    // Filter step: F += floor(alpha * (x - F) / 256)
    assign alpha_sat = (filter_alpha_reg > dmsr_pkg::ALPHA_ONE) ? dmsr_pkg::ALPHA_ONE
                                                                : filter_alpha_reg;
    assign filt_diff = $signed({1'b0, in_sample_reg, 8'b0}) - $signed({1'b0, filt_cur});
    assign filt_prod = (FW+11)'(filt_diff) * $signed((FW+11)'({1'b0, alpha_sat}));
    assign filt_sum  = $signed((FW+11)'({1'b0, filt_cur})) + (filt_prod >>> 8);
    assign filt_new  = filt_sum[FW-1:0];

    assign req_clamped = (in_req_reg > dmsr_pkg::SPEED_LIMIT)
                       ? dmsr_pkg::SPEED_LIMIT[dmsr_pkg::DUTY_W-1:0]
                       : in_req_reg[dmsr_pkg::DUTY_W-1:0];

    // Decode the command against the motor's state
    always_comb
    begin
        target_next = target_cur;
        speed_next  = speed_cur;
        filt_next   = filt_cur;
        action      = dmsr_pkg::ACT_UNCHANGED;
        duty        = '0;
        unique case (in_opcode_reg)
            dmsr_pkg::OP_TICK:
            begin
                if (ramp_period_reg != '0)
                begin
                    filt_next = filt_new;
                    if (target_cur != speed_cur)
                    begin
                        if (target_cur > speed_cur)
                            speed_next = speed_cur + 8'sd1;
                        else
                            speed_next = speed_cur - 8'sd1;
                        if (speed_next > 8'sd0)
                        begin
                            action = dmsr_pkg::ACT_RUN_CW;
                            duty   = speed_next[dmsr_pkg::DUTY_W-1:0];
                        end
                        else if (speed_next < 8'sd0)
                        begin
                            action = dmsr_pkg::ACT_RUN_CCW;
                            duty   = 7'(-speed_next);
                        end
                        else
                            action = dmsr_pkg::ACT_NEUTRAL;
                    end
                end
            end
            dmsr_pkg::OP_FORWARD:
            begin
                target_next = $signed({1'b0, req_clamped});
                if (ramp_period_reg == '0)
                begin
                    speed_next = $signed({1'b0, req_clamped});
                    action     = dmsr_pkg::ACT_RUN_CW;
                    duty       = req_clamped;
                end
            end
            dmsr_pkg::OP_BACKWARD:
            begin
                target_next = -$signed({1'b0, req_clamped});
                if (ramp_period_reg == '0)
                begin
                    speed_next = -$signed({1'b0, req_clamped});
                    action     = dmsr_pkg::ACT_RUN_CCW;
                    duty       = req_clamped;
                end
            end
            dmsr_pkg::OP_BRAKE_SUPPLY:
            begin
                target_next = '0;
                speed_next  = '0;
                action      = dmsr_pkg::ACT_BRAKE_SUPPLY;
            end
            dmsr_pkg::OP_BRAKE_GROUND:
            begin
                target_next = '0;
                speed_next  = '0;
                action      = dmsr_pkg::ACT_BRAKE_GROUND;
            end
            default:
            begin
                action = dmsr_pkg::ACT_UNCHANGED;
            end
        endcase
    end

    // Write back the addressed motor's state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                target_reg[i] <= '0;
                speed_reg[i]  <= '0;
                filt_reg[i]   <= '0;
            end
        end
        else if (advance && motor_ok)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                if (int'(in_motor_reg) == i)
                begin
                    target_reg[i] <= target_next;
                    speed_reg[i]  <= speed_next;
                    filt_reg[i]   <= filt_next;
                end
            end
        end
    end

    // Result register: load on advance, drop once taken
    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_motor_reg <= in_motor_reg;
            if (motor_ok)
            begin
                out_action_reg <= action;
                out_duty_reg   <= duty;
                out_target_reg <= target_next;
                out_speed_reg  <= speed_next;
                out_filt_reg   <= filt_next[FW-1:8];
            end
            else
            begin
                out_action_reg <= dmsr_pkg::ACT_UNCHANGED;
                out_duty_reg   <= '0;
                out_target_reg <= '0;
                out_speed_reg  <= '0;
                out_filt_reg   <= '0;
            end
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.motor_id         = out_motor_reg;
    assign out_ch.drive_action     = out_action_reg;
    assign out_ch.duty             = out_duty_reg;
    assign out_ch.target_speed     = out_target_reg;
    assign out_ch.present_speed    = out_speed_reg;
    assign out_ch.filtered_current = out_filt_reg;

    // A new result only ever follows a held command
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg))
        else $error("result appeared without a command in the stage");

    // Stored speed of motor 0 stays within the limit
    a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_reg[0] >= -8'sd100) && (speed_reg[0] <= 8'sd100))
        else $error("motor 0 speed out of range");

    // Duty is reported only with a run action
    a_duty_only_when_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_duty_reg != '0)) |->
        ((out_action_reg == dmsr_pkg::ACT_RUN_CW) ||
         (out_action_reg == dmsr_pkg::ACT_RUN_CCW)))
        else $error("nonzero duty without a run action");

    // A tick in immediate mode leaves motor 0 untouched
    a_tick_ignored_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_opcode_reg == dmsr_pkg::OP_TICK) && (ramp_period_reg == '0)) |=>
        ($stable(speed_reg[0]) && $stable(filt_reg[0])))
        else $error("tick changed state while ramp period is zero");

endmodule

/* tb/tb_dual_motor_speed_ramp.sv */
// Self-checking testbench for the dual motor speed ramp block: directed
// command and ramp cases, then random traffic under several register settings.
// Depends on dmsr_pkg, dmsr_in_if, dmsr_out_if and dual_motor_speed_ramp.
module tb_dual_motor_speed_ramp;

    localparam int SENSE_BITS  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 225;

    // Local copies of the package widths used in size casts
    localparam int RAMP_W  = dmsr_pkg::RAMP_W;
    localparam int ALPHA_W = dmsr_pkg::ALPHA_W;
    localparam int REQ_W   = dmsr_pkg::REQ_W;
    localparam int DUTY_W  = dmsr_pkg::DUTY_W;
    localparam int APB_AW  = dmsr_pkg::APB_AW;
    localparam int APB_DW  = dmsr_pkg::APB_DW;

    // One result beat, as the block reports it
    typedef struct packed {
        logic                  motor_id;
        dmsr_pkg::action_t     drive_action;
        logic [DUTY_W-1:0]     duty;
        dmsr_pkg::speed_t      target_speed;
        dmsr_pkg::speed_t      present_speed;
        logic [SENSE_BITS-1:0] filtered_current;
    } drive_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    dmsr_in_if  #(.SENSE_BITS(SENSE_BITS)) cmd_ch();
    dmsr_out_if #(.SENSE_BITS(SENSE_BITS)) res_ch();

    dual_motor_speed_ramp #(
        .NUM_MOTORS(2),
        .SENSE_BITS(SENSE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (cmd_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow registers and per-motor state of the predictor
    logic [RAMP_W-1:0]       ramp_q;
    logic [ALPHA_W-1:0]      alpha_q;
    int                      tgt_q [2];
    int                      spd_q [2];
    logic [SENSE_BITS+7:0]   filt_q [2];

    drive_result_t expected_drive_q [$];

    int  err_cnt;
    int  cycle_cnt;
    int  cmd_beats;
    int  result_beats;
    int  live_ticks;
    int  reg_writes;
    int  peak_speed;
    bit  steady;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_drive_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // Work out the result of one command and advance the predictor state
    function automatic drive_result_t predict_drive(dmsr_pkg::opcode_t op, logic m,
                                                    logic [REQ_W-1:0] req_in,
                                                    logic [SENSE_BITS-1:0] smp);
        drive_result_t r;
        int     req;
        int     sp;
        longint x;
        longint f;
        longint a;
        longint p;
        r = '0;
        r.motor_id = m;
        r.drive_action = dmsr_pkg::ACT_UNCHANGED;
        req = (req_in > dmsr_pkg::SPEED_LIMIT) ? int'(dmsr_pkg::SPEED_LIMIT) : int'(req_in);
        case (op)
            dmsr_pkg::OP_TICK:
            begin
                if (ramp_q != '0)
                begin
                    // First-order filter in Q8, floor toward minus infinity
                    x = longint'(smp) << 8;
                    f = longint'(filt_q[m]);
                    a = (alpha_q > dmsr_pkg::ALPHA_ONE) ? longint'(dmsr_pkg::ALPHA_ONE)
                                                        : longint'(alpha_q);
                    p = a * (x - f);
                    f = f + (p >>> 8);
                    filt_q[m] = f[SENSE_BITS+7:0];
                    live_ticks++;
                    // Step one unit toward the target
                    sp = spd_q[m];
                    if (tgt_q[m] > sp)
                        sp++;
                    else if (tgt_q[m] < sp)
                        sp--;
                    if (sp != spd_q[m])
                    begin
                        spd_q[m] = sp;
                        if (sp > 0)
                        begin
                            r.drive_action = dmsr_pkg::ACT_RUN_CW;
                            r.duty = DUTY_W'(sp);
                        end
                        else if (sp < 0)
                        begin
                            r.drive_action = dmsr_pkg::ACT_RUN_CCW;
                            r.duty = DUTY_W'(-sp);
                        end
                        else
                            r.drive_action = dmsr_pkg::ACT_NEUTRAL;
                    end
                end
            end
            dmsr_pkg::OP_FORWARD:
            begin
                tgt_q[m] = req;
                if (ramp_q == '0)
                begin
                    spd_q[m] = req;
                    r.drive_action = dmsr_pkg::ACT_RUN_CW;
                    r.duty = DUTY_W'(req);
                end
            end
            dmsr_pkg::OP_BACKWARD:
            begin
                tgt_q[m] = -req;
                if (ramp_q == '0)
                begin
                    spd_q[m] = -req;
                    r.drive_action = dmsr_pkg::ACT_RUN_CCW;
                    r.duty = DUTY_W'(req);
                end
            end
            dmsr_pkg::OP_BRAKE_SUPPLY, dmsr_pkg::OP_BRAKE_GROUND:
            begin
                tgt_q[m] = 0;
                spd_q[m] = 0;
                r.drive_action = (op == dmsr_pkg::OP_BRAKE_SUPPLY) ? dmsr_pkg::ACT_BRAKE_SUPPLY
                                                                   : dmsr_pkg::ACT_BRAKE_GROUND;
            end
            default:
            begin
            end
        endcase
        if (spd_q[m] > peak_speed)
            peak_speed = spd_q[m];
        if (-spd_q[m] > peak_speed)
            peak_speed = -spd_q[m];
        r.target_speed     = dmsr_pkg::speed_t'(tgt_q[m]);
        r.present_speed    = dmsr_pkg::speed_t'(spd_q[m]);
        r.filtered_current = filt_q[m][SENSE_BITS+7:8];
        return r;
    endfunction

    // Check result beats against the oldest prediction, predict each command beat
    always @(posedge clk)
    begin : beat_monitor
        drive_result_t got;
        drive_result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                result_beats++;
                got.motor_id         = res_ch.motor_id;
                got.drive_action     = res_ch.drive_action;
                got.duty             = res_ch.duty;
                got.target_speed     = res_ch.target_speed;
                got.present_speed    = res_ch.present_speed;
                got.filtered_current = res_ch.filtered_current;
                if (expected_drive_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result beat: motor %0d act %0d duty %0d",
                                 got.motor_id, got.drive_action, got.duty);
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (got !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("result mismatch at cycle %0d", cycle_cnt);
                            $display({"  expected motor %0d act %0d duty %0d",
                                      " tgt %0d spd %0d cur %0d"},
                                     want.motor_id, want.drive_action, want.duty,
                                     want.target_speed, want.present_speed,
                                     want.filtered_current);
                            $display({"  actual   motor %0d act %0d duty %0d",
                                      " tgt %0d spd %0d cur %0d"},
                                     got.motor_id, got.drive_action, got.duty,
                                     got.target_speed, got.present_speed,
                                     got.filtered_current);
                        end
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_beats++;
                expected_drive_q.push_back(predict_drive(cmd_ch.opcode, cmd_ch.motor_select,
                                                         cmd_ch.speed_request,
                                                         cmd_ch.sense_sample));
            end
        end
    end

    // Result side: stall a random number of cycles before each beat
    initial
    begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // Send one command beat after a random gap; valid stays high on return
    task automatic send_cmd(dmsr_pkg::opcode_t op, logic m, logic [REQ_W-1:0] req,
                            logic [SENSE_BITS-1:0] smp);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.opcode        <= op;
        cmd_ch.motor_select  <= m;
        cmd_ch.speed_request <= req;
        cmd_ch.sense_sample  <= smp;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // Hold commands until every predicted result has arrived
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == dmsr_pkg::REG_RAMP_PERIOD)
            ramp_q = val[RAMP_W-1:0];
        else
            alpha_q = val[ALPHA_W-1:0];
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(logic idx);
        logic [APB_DW-1:0] want;
        want = (idx == dmsr_pkg::REG_RAMP_PERIOD) ? APB_DW'(ramp_q) : APB_DW'(alpha_q);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("register %0d read back %0h, expected %0h", idx, prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program both registers with junk in the unused upper bits, then read back
    task automatic set_config(logic [RAMP_W-1:0] ramp, logic [ALPHA_W-1:0] alpha);
        logic [APB_DW-1:0] junk;
        drain_results();
        junk = $urandom();
        junk[RAMP_W-1:0] = ramp;
        write_reg(dmsr_pkg::REG_RAMP_PERIOD, junk);
        junk = $urandom();
        junk[ALPHA_W-1:0] = alpha;
        write_reg(dmsr_pkg::REG_FILTER_ALPHA, junk);
        check_reg(dmsr_pkg::REG_RAMP_PERIOD);
        check_reg(dmsr_pkg::REG_FILTER_ALPHA);
    endtask

    // Reset values, immediate mode, clamping, brakes, ignored ticks, bad opcodes
    task automatic test_immediate_mode();
        check_reg(dmsr_pkg::REG_RAMP_PERIOD);
        check_reg(dmsr_pkg::REG_FILTER_ALPHA);
        send_cmd(dmsr_pkg::OP_FORWARD, 1'b0, 8'd255, '0);
        send_cmd(dmsr_pkg::OP_FORWARD, 1'b1, 8'd0, '0);
        send_cmd(dmsr_pkg::OP_BACKWARD, 1'b0, 8'd100, '0);
        send_cmd(dmsr_pkg::OP_BACKWARD, 1'b1, 8'd101, '1);
        send_cmd(dmsr_pkg::OP_TICK, 1'b0, 8'd55, 12'hfff);
        send_cmd(dmsr_pkg::OP_BRAKE_SUPPLY, 1'b0, 8'd20, '0);
        send_cmd(dmsr_pkg::OP_BRAKE_GROUND, 1'b1, 8'd20, '0);
        send_cmd(dmsr_pkg::opcode_t'(3'd5), 1'b0, 8'd77, 12'h0f0);
        send_cmd(dmsr_pkg::opcode_t'(3'd7), 1'b1, 8'd99, 12'hf0f);
    endtask

    // Stepping toward the target, the zero crossing, ticks at target
    task automatic test_ramp_stepping();
        set_config(8'd255, 9'd511);
        send_cmd(dmsr_pkg::OP_FORWARD, 1'b0, 8'd1, '0);
        send_cmd(dmsr_pkg::OP_TICK, 1'b0, 8'd0, 12'hfff);
        send_cmd(dmsr_pkg::OP_TICK, 1'b0, 8'd0, 12'h000);
        send_cmd(dmsr_pkg::OP_BACKWARD, 1'b0, 8'd1, '0);
        send_cmd(dmsr_pkg::OP_TICK, 1'b0, 8'd0, 12'h800);
        send_cmd(dmsr_pkg::OP_TICK, 1'b0, 8'd0, 12'h7ff);
        send_cmd(dmsr_pkg::OP_BRAKE_GROUND, 1'b0, 8'd0, '0);
    endtask

    // Filter weight at zero, one step, unity, and rounding on a falling input
    task automatic test_filter_weights();
        set_config(8'd1, 9'd0);
        send_cmd(dmsr_pkg::OP_TICK, 1'b1, 8'd0, 12'hfff);
        set_config(8'd1, 9'd1);
        send_cmd(dmsr_pkg::OP_TICK, 1'b1, 8'd0, 12'hfff);
        send_cmd(dmsr_pkg::OP_TICK, 1'b1, 8'd0, 12'h000);
        set_config(8'd1, dmsr_pkg::ALPHA_ONE);
        send_cmd(dmsr_pkg::OP_TICK, 1'b1, 8'd0, 12'hfff);
    endtask

    // One random burst: mostly a speed command followed by a run of ticks,
    // otherwise a few arbitrary beats; every beat sent counts toward the phase
    task automatic run_burst(inout int counted);
        logic              m;
        logic [REQ_W-1:0]  req;
        dmsr_pkg::opcode_t op;
        int                n;
        steady = ($urandom_range(0, 4) == 0);
        m = 1'(($urandom_range(0, 1)));
        if ($urandom_range(0, 9) < 6)
        begin
            op  = ($urandom_range(0, 1) == 0) ? dmsr_pkg::OP_FORWARD : dmsr_pkg::OP_BACKWARD;
            req = ($urandom_range(0, 1) == 0) ? REQ_W'($urandom_range(0, 100))
                                               : REQ_W'($urandom());
            send_cmd(op, m, req, SENSE_BITS'($urandom()));
            counted++;
            if (ramp_q != '0 && counted < PHASE_ITEMS)
            begin
                // Trim the tick run to what is left of the phase
                n = $urandom_range(1, 130);
                if (n > PHASE_ITEMS - counted)
                    n = PHASE_ITEMS - counted;
                repeat (n)
                begin
                    // Mostly the commanded motor, now and then the other one
                    send_cmd(dmsr_pkg::OP_TICK, ($urandom_range(0, 7) == 0) ? ~m : m,
                             REQ_W'($urandom()), SENSE_BITS'($urandom()));
                end
                counted += n;
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                op = dmsr_pkg::opcode_t'($urandom_range(0, 7));
                send_cmd(op, 1'(($urandom_range(0, 1))), REQ_W'($urandom()),
                         SENSE_BITS'($urandom()));
                counted++;
            end
        end
    endtask

    // Random traffic across register settings, extremes included
    task automatic test_random_traffic();
        int counted;
        logic [RAMP_W-1:0]  ramp;
        logic [ALPHA_W-1:0] alpha;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin ramp = 8'd1;   alpha = dmsr_pkg::ALPHA_RESET; end
                1: begin ramp = 8'd255; alpha = 9'd0;        end
                2: begin ramp = 8'd0;   alpha = 9'd511;      end
                3: begin ramp = RAMP_W'($urandom_range(2, 254));
                         alpha = ALPHA_W'($urandom_range(0, 511)); end
                4: begin ramp = RAMP_W'($urandom_range(1, 255));
                         alpha = dmsr_pkg::ALPHA_ONE; end
                default: begin ramp = 8'd7; alpha = 9'd300; end
            endcase
            set_config(ramp, alpha);
            counted = 0;
            while (counted < PHASE_ITEMS)
                run_burst(counted);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        err_cnt      = 0;
        cycle_cnt    = 0;
        cmd_beats    = 0;
        result_beats = 0;
        live_ticks   = 0;
        reg_writes   = 0;
        peak_speed   = 0;
        steady       = 1'b0;
        ramp_q       = dmsr_pkg::RAMP_RESET;
        alpha_q      = dmsr_pkg::ALPHA_RESET;
        for (int i = 0; i < 2; i++)
        begin
            tgt_q[i]  = 0;
            spd_q[i]  = 0;
            filt_q[i] = '0;
        end
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.opcode        <= dmsr_pkg::OP_TICK;
        cmd_ch.motor_select  <= 1'b0;
        cmd_ch.speed_request <= '0;
        cmd_ch.sense_sample  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_immediate_mode();
        test_ramp_stepping();
        test_filter_weights();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d command beats (%0d filtered ramp ticks), %0d result beats checked,",
                 cmd_beats, live_ticks, result_beats);
        $display("%0d register writes; peak speed magnitude %0d; %0d errors found.",
                 reg_writes, peak_speed, err_cnt);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
